// File: hw/rtl/aes_pkg.sv
`timescale 1ns / 1ps

package aes_pkg;

    localparam int NumRounds = 10;
    localparam int KeyW      = 64;
    localparam int BlkW      = 128;

    localparam logic [0:0] REG_KEY_HI = 1'b0;
    localparam logic [0:0] REG_KEY_LO = 1'b1;

    typedef logic [BlkW-1:0] block_t;

    typedef struct packed {
        logic   valid;
        block_t data;
        block_t rkey;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // Byte n of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input block_t b, input int n);
        return b[BlkW-1-8*n -: 8];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// File: hw/rtl/aes128_block_encrypt_top.sv
`timescale 1ns / 1ps
// Channel | Handshake           | Payload
// in      | in_valid / in_ready  | plain_hi, plain_lo
// out     | out_valid / out_ready| cipher_hi, cipher_lo
// cfg     | cfg_we               | cfg_index, cfg_data
//
// Eleven register stages (key addition, then one cell per round).
// One item enters per cycle while the output does not stall; the round cells all move together.
// Reset clears the valid bits; key registers reset to zero.
// A stall at the output freezes the whole chain of cells.

module aes128_block_encrypt_top
    import aes_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [KeyW-1:0] cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [KeyW-1:0] plain_hi,
    input  logic [KeyW-1:0] plain_lo,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [KeyW-1:0] cipher_hi,
    output logic [KeyW-1:0] cipher_lo
);

    logic [KeyW-1:0] key_hi_reg;
    logic [KeyW-1:0] key_lo_reg;
    stage_t          st [NumRounds+1];
    stage_t          s0_reg;
    logic            en;

    // Advance unless the last stage holds an item nobody takes
    assign en       = !st[NumRounds].valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_HI: key_hi_reg <= cfg_data;
                REG_KEY_LO: key_lo_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
        end
        else if (en)
        begin
            s0_reg.valid <= in_valid;
            s0_reg.data  <= {plain_hi, plain_lo} ^ {key_hi_reg, key_lo_reg};
            s0_reg.rkey  <= {key_hi_reg, key_lo_reg};
        end
    end

    assign st[0] = s0_reg;

    for (genvar g = 0; g < NumRounds; g++)
    begin : g_round
        aes_round_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .rcon (RCON[g]),
            .last (g == NumRounds - 1),
            .prev (st[g]),
            .cur  (st[g+1])
        );
    end

    assign out_valid = st[NumRounds].valid;
    assign cipher_hi = st[NumRounds].data[BlkW-1 -: KeyW];
    assign cipher_lo = st[NumRounds].data[KeyW-1:0];

endmodule

// File: hw/rtl/aes_round_cell.sv
`timescale 1ns / 1ps

module aes_round_cell
    import aes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] rcon,
    input  logic       last,
    input  stage_t     prev,
    output stage_t     cur
);

    stage_t     cur_reg;
    stage_t     cur_next;
    logic [7:0] sb [16];
    logic [7:0] mc [16];
    logic [7:0] rk [16];
    logic [7:0] tw [4];

    always_comb
    begin
        // SubBytes with ShiftRows folded into the byte selection
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sb[r + 4*c] = SBOX[get_byte(prev.data, r + 4*((c + r) % 4))];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] all;
            all = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
            for (int r = 0; r < 4; r++)
            begin
                mc[4*c+r] = last ? sb[4*c+r]
                          : sb[4*c+r] ^ all ^ gf_double(sb[4*c+r] ^ sb[4*c+((r+1)%4)]);
            end
        end
        // Next round key, built alongside the data
        tw[0] = SBOX[get_byte(prev.rkey, 13)] ^ rcon;
        tw[1] = SBOX[get_byte(prev.rkey, 14)];
        tw[2] = SBOX[get_byte(prev.rkey, 15)];
        tw[3] = SBOX[get_byte(prev.rkey, 12)];
        for (int k = 0; k < 4; k++)
        begin
            rk[k] = get_byte(prev.rkey, k) ^ tw[k];
        end
        for (int n = 4; n < 16; n++)
        begin
            rk[n] = get_byte(prev.rkey, n) ^ rk[n-4];
        end
        cur_next.valid = prev.valid;
        for (int n = 0; n < 16; n++)
        begin
            cur_next.rkey[BlkW-1-8*n -: 8] = rk[n];
            cur_next.data[BlkW-1-8*n -: 8] = mc[n] ^ rk[n];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else if (en)
        begin
            cur_reg <= cur_next;
        end
    end

    assign cur = cur_reg;

endmodule

// File: hw/rtl/aes_checker.sv
`timescale 1ns / 1ps

module aes_checker
    import aes_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [KeyW-1:0] cipher_hi,
    input logic [KeyW-1:0] cipher_lo
);

    // An output stall holds the result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cipher_hi) && $stable(cipher_lo))
        else $error("result changed while stalled");

    // Input side opens whenever the output is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during stall");

    // No result appears while the chain keeps advancing with no item entering it
    a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!out_valid, 1) && $past(in_ready, 11) && !$past(in_valid, 11)
        && $past(in_ready, 10) && $past(in_ready, 9) && $past(in_ready, 8)
        && $past(in_ready, 7) && $past(in_ready, 6) && $past(in_ready, 5)
        && $past(in_ready, 4) && $past(in_ready, 3) && $past(in_ready, 2)
        && $past(in_ready, 1) && $past(rst_n, 11) |-> !out_valid)
        else $error("spurious result");

endmodule

bind aes128_block_encrypt_top aes_checker u_aes_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cipher_hi(cipher_hi),
    .cipher_lo(cipher_lo)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import aes_pkg::*;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [0:0]      cfg_index;
    logic [KeyW-1:0] cfg_data;
    logic            in_valid;
    logic            in_ready;
    logic [KeyW-1:0] plain_hi;
    logic [KeyW-1:0] plain_lo;
    logic            out_valid;
    logic            out_ready;
    logic [KeyW-1:0] cipher_hi;
    logic [KeyW-1:0] cipher_lo;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_t;

    cipher_t     cipher_q[$];
    logic [63:0] key_hi_m;
    logic [63:0] key_lo_m;
    int          n_errors;
    int          hold_cycles;

    aes128_block_encrypt_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .plain_hi  (plain_hi),
        .plain_lo  (plain_lo),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cipher_hi (cipher_hi),
        .cipher_lo (cipher_lo)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Own S-box, built from the field inverse and the affine map
    logic [7:0] sub_lut [256];

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= x;
            x = xtime(x);
        end
        return p;
    endfunction

    task automatic build_sub_lut();
        logic [7:0] inv;
        logic [7:0] s;
        for (int v = 0; v < 256; v++)
        begin
            inv = 8'h00;
            for (int w = 1; w < 256; w++)
                if (gmul(v[7:0], w[7:0]) == 8'h01)
                    inv = w[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_lut[v] = s;
        end
    endtask

    function automatic cipher_t encrypt(input logic [63:0] ph, input logic [63:0] pl);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] sh [16];
        logic [7:0] t [4];
        logic [7:0] first;
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, all;
        cipher_t    res;
        rc = 8'h01;
        for (int n = 0; n < 8; n++)
        begin
            rk[n]     = key_hi_m[63-8*n -: 8];
            rk[8+n]   = key_lo_m[63-8*n -: 8];
            st[n]     = ph[63-8*n -: 8];
            st[8+n]   = pl[63-8*n -: 8];
        end
        for (int n = 16; n < 176; n += 4)
        begin
            for (int k = 0; k < 4; k++)
                t[k] = rk[n-4+k];
            if (n % 16 == 0)
            begin
                first = t[0];
                t[0] = sub_lut[t[1]] ^ rc;
                t[1] = sub_lut[t[2]];
                t[2] = sub_lut[t[3]];
                t[3] = sub_lut[first];
                rc = xtime(rc);
            end
            for (int k = 0; k < 4; k++)
                rk[n+k] = rk[n-16+k] ^ t[k];
        end
        for (int n = 0; n < 16; n++)
            st[n] ^= rk[n];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    sh[w+4*c] = sub_lut[st[w+4*((c+w)%4)]];
            st = sh;
            if (r < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[4*c];
                    a1 = st[4*c+1];
                    a2 = st[4*c+2];
                    a3 = st[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                    st[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                    st[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                    st[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
                end
            end
            for (int n = 0; n < 16; n++)
                st[n] ^= rk[16*r+n];
        end
        for (int n = 0; n < 8; n++)
        begin
            res.hi[63-8*n -: 8] = st[n];
            res.lo[63-8*n -: 8] = st[8+n];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        n_errors++;
    endtask

    task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_KEY_HI)
            key_hi_m = val;
        else
            key_lo_m = val;
    endtask

    // Idle between phases: drain the pipe, then let it settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (14) @(posedge clk);
    endtask

    task automatic set_key(input logic [63:0] kh, input logic [63:0] kl);
        wait_drained();
        write_key(REG_KEY_HI, kh);
        write_key(REG_KEY_LO, kl);
    endtask

    task automatic send_block(input logic [63:0] ph, input logic [63:0] pl,
                              input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        plain_hi <= ph;
        plain_lo <= pl;
        cipher_q.push_back(encrypt(ph, pl));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Output side: random stalls, a long hold-off on request
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cipher_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (cipher_q.size() == 0)
            begin
                report_mismatch("unexpected cipher_hi", cipher_hi, 64'h0);
            end
            else
            begin
                want = cipher_q.pop_front();
                if (cipher_hi !== want.hi)
                    report_mismatch("cipher_hi", cipher_hi, want.hi);
                if (cipher_lo !== want.lo)
                    report_mismatch("cipher_lo", cipher_lo, want.lo);
            end
        end
    end

    task automatic test_known_vector();
        set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1);
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
    endtask

    task automatic test_extremes();
        logic [63:0] pats [4];
        pats = '{64'h0, 64'hffffffffffffffff, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555};
        set_key(64'h0, 64'h0);
        for (int i = 0; i < 4; i++)
            send_block(pats[i], pats[3-i], 1'b0);
        set_key(64'hffffffffffffffff, 64'hffffffffffffffff);
        for (int i = 0; i < 4; i++)
            send_block(pats[i], pats[i], 1'b1);
        set_key(64'h8000000000000000, 64'h0000000000000001);
        send_block(64'h0, 64'h1, 1'b1);
        send_block(64'h8000000000000000, 64'h0, 1'b1);
    endtask

    task automatic test_random_blocks(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                set_key({$urandom, $urandom}, {$urandom, $urandom});
            send_block({$urandom, $urandom}, {$urandom, $urandom}, (i % 70) >= 20);
        end
    endtask

    // Hold the output off so the pipe fills and stalls the input
    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 40;
        for (int i = 0; i < 30; i++)
            send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    endtask

    initial
    begin
        n_errors    = 0;
        hold_cycles = 0;
        key_hi_m    = '0;
        key_lo_m    = '0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_KEY_HI;
        cfg_data    = '0;
        in_valid    = 1'b0;
        plain_hi    = '0;
        plain_lo    = '0;
        build_sub_lut();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Reset key of zero
        send_block(64'h0, 64'h0, 1'b0);
        test_known_vector();
        test_extremes();
        test_backpressure();
        test_random_blocks(180);
        test_backpressure();
        test_random_blocks(180);
        wait_drained();
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_round_cell.sv
hw/rtl/aes128_block_encrypt_top.sv
hw/rtl/aes_checker.sv
tb/tb.sv
